[rtl/snt_pkg.sv]
// ----------------------------------------------------------------------------
// snt_pkg: shared definitions for the span nesting tracker
// Event kinds, CSR indexes, stack geometry and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package snt_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] KIND_BEGIN    = 2'd0;
   localparam logic [1:0] KIND_END      = 2'd1;
   localparam logic [1:0] KIND_EXPLICIT = 2'd2;

   localparam logic [1:0] CSR_ENABLE     = 2'd0;
   localparam logic [1:0] CSR_SPAN_BASE  = 2'd1;
   localparam logic [1:0] CSR_TRACE_BASE = 2'd2;
   localparam logic [1:0] CSR_THREAD_TAG = 2'd3;

   // one stack entry
   typedef struct packed {
      logic [8:0]  name;
      logic [63:0] span;
      logic [63:0] parent;
      logic [63:0] start;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch the request, clear the result
      logic do_begin;
      logic do_explicit;
      logic scan_start;   // point at the stack top
      logic scan_dec;     // step one entry down
      logic do_found;     // pop to the matched entry and build its record
      logic top_load;     // refresh the top span from the read data
      logic rsp_load;     // move the result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] kind;
      logic       end_ok;    // handle nonzero and stack not empty
      logic       match;     // read entry carries the handle
      logic       idx_zero;
      logic       rsp_free;
   } status_type;

endpackage

[rtl/snt_ctrl.sv]
// ----------------------------------------------------------------------------
// snt_ctrl: sequencing state machine
// Walks one transaction through execute, stack search and response.
// ----------------------------------------------------------------------------
module snt_ctrl
   import snt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_SCAN_RD  = 3'd2;
   localparam logic [2:0] S_SCAN_CHK = 3'd3;
   localparam logic [2:0] S_TOP_RD   = 3'd4;
   localparam logic [2:0] S_TOP_CHK  = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            unique case (st.kind)
               KIND_BEGIN:    cmd.do_begin = 1'b1;
               KIND_EXPLICIT: cmd.do_explicit = 1'b1;
               KIND_END: begin
                  if (st.end_ok) begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN_RD;
                  end
               end
               default: ;
            endcase
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (st.match) begin
               cmd.do_found = 1'b1;
               state_in     = st.idx_zero ? S_DONE : S_TOP_RD;
            end else if (st.idx_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.scan_dec = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_TOP_RD: state_in = S_TOP_CHK;
         S_TOP_CHK: begin
            cmd.top_load = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[rtl/snt_dpath.sv]
// ----------------------------------------------------------------------------
// snt_dpath: span stack, id counters, CSRs and result registers
// Stack entries live in a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
module snt_dpath
   import snt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  st,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_name_tag,
   input  logic [63:0] req_handle,
   input  logic [63:0] req_start_time,
   input  logic [63:0] req_stop_time,
   input  logic [63:0] req_given_trace,
   input  logic [63:0] req_given_parent,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_new_handle,
   output logic        rsp_emitted,
   output logic [8:0]  rsp_rec_name,
   output logic [63:0] rsp_rec_trace,
   output logic [63:0] rsp_rec_span,
   output logic [63:0] rsp_rec_parent,
   output logic [63:0] rsp_rec_start,
   output logic [63:0] rsp_rec_stop,
   output logic [31:0] rsp_rec_thread,
   output logic [63:0] rsp_cur_trace,
   output logic [63:0] rsp_cur_span
);

   // configuration
   logic        enable_ff;
   logic [63:0] span_base_ff, trace_base_ff;
   logic [31:0] thread_ff;

   // captured request
   logic [1:0]  kind_ff;
   logic [8:0]  name_ff;
   logic [63:0] handle_ff, start_ff, stop_ff, gtrace_ff, gparent_ff;

   // tracker state
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [63:0]      active_ff, span_cnt_ff, trace_cnt_ff, top_span_ff;

   // working result
   logic [63:0] res_handle_ff, res_trace_ff, res_span_ff, res_parent_ff;
   logic [63:0] res_start_ff, res_stop_ff;
   logic        res_emit_ff;
   logic [8:0]  res_name_ff;
   logic [31:0] res_thread_ff;

   // output register
   logic        out_valid_ff;
   logic [63:0] out_handle_ff, out_trace_ff, out_span_ff, out_parent_ff;
   logic [63:0] out_start_ff, out_stop_ff, out_cur_trace_ff, out_cur_span_ff;
   logic        out_emit_ff;
   logic [8:0]  out_name_ff;
   logic [31:0] out_thread_ff;

   // stack memory
   entry_type mem [STACK_DEPTH];
   entry_type rd_ff;
   entry_type wr_entry;
   logic      wr_en;

   logic [63:0] sid, tid;
   logic        can_push;

   assign sid      = span_base_ff + span_cnt_ff + 64'd1;
   assign tid      = trace_base_ff + trace_cnt_ff + 64'd1;
   assign can_push = enable_ff && (count_ff < CNT_W'(STACK_DEPTH));

   assign wr_en           = cmd.do_begin && can_push && (sid != 64'd0);
   assign wr_entry.name   = name_ff;
   assign wr_entry.span   = sid;
   assign wr_entry.parent = (count_ff != '0) ? top_span_ff : 64'd0;
   assign wr_entry.start  = start_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      rd_ff <= mem[idx_ff];
   end

   assign st.kind     = kind_ff;
   assign st.end_ok   = (handle_ff != 64'd0) && (count_ff != '0);
   assign st.match    = (rd_ff.span == handle_ff);
   assign st.idx_zero = (idx_ff == '0);
   assign st.rsp_free = !out_valid_ff || rsp_ready;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         span_base_ff  <= 64'd1;
         trace_base_ff <= 64'd1;
         thread_ff     <= 32'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:     enable_ff     <= csr_wdata[0];
            CSR_SPAN_BASE:  span_base_ff  <= csr_wdata;
            CSR_TRACE_BASE: trace_base_ff <= csr_wdata;
            CSR_THREAD_TAG: thread_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         name_ff    <= req_name_tag;
         handle_ff  <= req_handle;
         start_ff   <= req_start_time;
         stop_ff    <= req_stop_time;
         gtrace_ff  <= req_given_trace;
         gparent_ff <= req_given_parent;
      end
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         active_ff    <= 64'd0;
         span_cnt_ff  <= 64'd0;
         trace_cnt_ff <= 64'd0;
         top_span_ff  <= 64'd0;
      end else begin
         if (cmd.do_begin && can_push) begin
            span_cnt_ff <= span_cnt_ff + 64'd1;
            if (sid != 64'd0) begin
               if (count_ff == '0) begin
                  active_ff    <= tid;
                  trace_cnt_ff <= trace_cnt_ff + 64'd1;
               end
               count_ff    <= count_ff + CNT_W'(1);
               top_span_ff <= sid;
            end
         end
         if (cmd.do_explicit && enable_ff) begin
            span_cnt_ff <= span_cnt_ff + 64'd1;
            if (gtrace_ff == 64'd0) begin
               trace_cnt_ff <= trace_cnt_ff + 64'd1;
            end
         end
         if (cmd.scan_start) begin
            idx_ff <= IDX_W'(count_ff - CNT_W'(1));
         end
         if (cmd.scan_dec) begin
            idx_ff <= idx_ff - IDX_W'(1);
         end
         if (cmd.do_found) begin
            count_ff <= CNT_W'(idx_ff);
            idx_ff   <= idx_ff - IDX_W'(1);
         end
         if (cmd.top_load) begin
            top_span_ff <= rd_ff.span;
         end
      end
   end

   // working result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_handle_ff <= 64'd0;
         res_emit_ff   <= 1'b0;
         res_name_ff   <= 9'd0;
         res_trace_ff  <= 64'd0;
         res_span_ff   <= 64'd0;
         res_parent_ff <= 64'd0;
         res_start_ff  <= 64'd0;
         res_stop_ff   <= 64'd0;
         res_thread_ff <= 32'd0;
      end
      if (wr_en) begin
         res_handle_ff <= sid;
      end
      if (cmd.do_explicit && enable_ff) begin
         res_emit_ff   <= 1'b1;
         res_name_ff   <= name_ff;
         res_trace_ff  <= (gtrace_ff != 64'd0) ? gtrace_ff : tid;
         res_span_ff   <= sid;
         res_parent_ff <= gparent_ff;
         res_start_ff  <= start_ff;
         res_stop_ff   <= stop_ff;
         res_thread_ff <= thread_ff;
      end
      if (cmd.do_found) begin
         res_emit_ff   <= 1'b1;
         res_name_ff   <= rd_ff.name;
         res_trace_ff  <= active_ff;
         res_span_ff   <= rd_ff.span;
         res_parent_ff <= rd_ff.parent;
         res_start_ff  <= rd_ff.start;
         res_stop_ff   <= stop_ff;
         res_thread_ff <= thread_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_handle_ff    <= res_handle_ff;
         out_emit_ff      <= res_emit_ff;
         out_name_ff      <= res_name_ff;
         out_trace_ff     <= res_trace_ff;
         out_span_ff      <= res_span_ff;
         out_parent_ff    <= res_parent_ff;
         out_start_ff     <= res_start_ff;
         out_stop_ff      <= res_stop_ff;
         out_thread_ff    <= res_thread_ff;
         out_cur_trace_ff <= (count_ff != '0) ? active_ff : 64'd0;
         out_cur_span_ff  <= (count_ff != '0) ? top_span_ff : 64'd0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_new_handle = out_handle_ff;
   assign rsp_emitted    = out_emit_ff;
   assign rsp_rec_name   = out_name_ff;
   assign rsp_rec_trace  = out_trace_ff;
   assign rsp_rec_span   = out_span_ff;
   assign rsp_rec_parent = out_parent_ff;
   assign rsp_rec_start  = out_start_ff;
   assign rsp_rec_stop   = out_stop_ff;
   assign rsp_rec_thread = out_thread_ff;
   assign rsp_cur_trace  = out_cur_trace_ff;
   assign rsp_cur_span   = out_cur_span_ff;

endmodule

[rtl/span_nesting_tracker.sv]
// ----------------------------------------------------------------------------
// span_nesting_tracker: per-thread nested tracing span stack
// Begin pushes, end pops to the matching span, explicit emits directly.
// ----------------------------------------------------------------------------
// Sequencing: begin, explicit and rejected events pass through execute and then
// done before rsp_valid; an end reads and checks one entry per search step from
// the top, then refetches the new top when entries remain below the match.
// Throughput: one transaction at a time; the next is accepted the cycle after
// the response is loaded. The stack memory port is read once per search
// step with a registered output; a held response stalls the sequencer in
// its final state.
// Reset (synchronous): empty stack, counters and trace cleared, tracing off,
// both id bases 1. No clearing pass: stack entries are read only below depth.
// ----------------------------------------------------------------------------
module span_nesting_tracker
   import snt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_name_tag,
   input  logic [63:0] req_handle,
   input  logic [63:0] req_start_time,
   input  logic [63:0] req_stop_time,
   input  logic [63:0] req_given_trace,
   input  logic [63:0] req_given_parent,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_new_handle,
   output logic        rsp_emitted,
   output logic [8:0]  rsp_rec_name,
   output logic [63:0] rsp_rec_trace,
   output logic [63:0] rsp_rec_span,
   output logic [63:0] rsp_rec_parent,
   output logic [63:0] rsp_rec_start,
   output logic [63:0] rsp_rec_stop,
   output logic [31:0] rsp_rec_thread,
   output logic [63:0] rsp_cur_trace,
   output logic [63:0] rsp_cur_span,
   // CSR write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cmd_type    cmd;
   status_type st;

   // Sequencer: accept a transaction, run it, hold in the final state until
   // the output register frees up.
   snt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Datapath: stack memory, id generation, CSRs and the response register.
   snt_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_kind         (req_kind),
      .req_name_tag     (req_name_tag),
      .req_handle       (req_handle),
      .req_start_time   (req_start_time),
      .req_stop_time    (req_stop_time),
      .req_given_trace  (req_given_trace),
      .req_given_parent (req_given_parent),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_new_handle   (rsp_new_handle),
      .rsp_emitted      (rsp_emitted),
      .rsp_rec_name     (rsp_rec_name),
      .rsp_rec_trace    (rsp_rec_trace),
      .rsp_rec_span     (rsp_rec_span),
      .rsp_rec_parent   (rsp_rec_parent),
      .rsp_rec_start    (rsp_rec_start),
      .rsp_rec_stop     (rsp_rec_stop),
      .rsp_rec_thread   (rsp_rec_thread),
      .rsp_cur_trace    (rsp_cur_trace),
      .rsp_cur_span     (rsp_cur_span)
   );

   // An accepted transaction drops req_ready in the following cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // A response only appears after the sequencer loads it.
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("response raised without a load");

   // A search step never runs past the bottom of the stack.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_dec |-> !st.idx_zero)
      else $error("stack search stepped below entry zero");

endmodule
